// ----- sv/fir_pkg.sv -----
// Package for the Q15 FIR filter: types, sizes and codes.
// Used by fir_cell, fir_filter_q15 and the testbench; depends on nothing else.
`timescale 1ns / 1ps

package fir_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int COEFF_W    = 16;
   localparam int ACC_W      = 32;
   localparam int FRAC_SHIFT = 15;
   localparam int OUT_W      = ACC_W - FRAC_SHIFT;
   localparam int TAP_IDX_W  = 5;

   localparam logic MODE_SAMPLE = 1'b0;
   localparam logic MODE_COEFF  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROD,
      ST_RUN,
      ST_HOLD
   } state_type;

   // Controls broadcast to every cell of the chain.
   typedef struct packed {
      logic shift_en;
      logic prod_en;
   } cell_ctrl_type;

endpackage

// ----- sv/fir_cell.sv -----
// One tap cell of the FIR chain: a sample, a coefficient, a product and a
// stage of the running sum. Depends on fir_pkg.
`timescale 1ns / 1ps

module fir_cell (
   input  logic                                     clock,
   input  logic                                     reset,
   input  fir_pkg::cell_ctrl_type                   ctrl,
   input  logic                                     coeff_we,
   input  logic signed [fir_pkg::COEFF_W-1:0]       coeff_data,
   input  logic signed [fir_pkg::SAMPLE_W-1:0]      sample_nbr,
   output logic signed [fir_pkg::SAMPLE_W-1:0]      sample_out,
   input  logic signed [fir_pkg::ACC_W-1:0]         sum_prev,
   input  logic                                     sum_valid_prev,
   output logic signed [fir_pkg::ACC_W-1:0]         sum_out,
   output logic                                     sum_valid_out
);

   logic signed [fir_pkg::COEFF_W-1:0]  coeff_ff, coeff_in;
   logic signed [fir_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic signed [fir_pkg::ACC_W-1:0]    prod_ff, prod_in;
   logic signed [fir_pkg::ACC_W-1:0]    sum_ff, sum_in;
   logic                                valid_ff, valid_in;

   always_comb begin
      coeff_in  = coeff_we ? coeff_data : coeff_ff;
      sample_in = ctrl.shift_en ? sample_nbr : sample_ff;
      prod_in   = ctrl.prod_en ? fir_pkg::ACC_W'(sample_ff * coeff_ff) : prod_ff;
      // The sum wraps at 32 bits, as the accumulation is defined.
      sum_in    = sum_valid_prev ? (sum_prev + prod_ff) : sum_ff;
      valid_in  = sum_valid_prev;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coeff_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         coeff_ff <= coeff_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff <= sample_in;
      prod_ff   <= prod_in;
      sum_ff    <= sum_in;
   end

   assign sample_out    = sample_ff;
   assign sum_out       = sum_ff;
   assign sum_valid_out = valid_ff;

endmodule

// ----- sv/fir_filter_q15.sv -----
// Q15 FIR filter top level: request decode, fill count, control sequencer,
// the chain of tap cells and the result register. Depends on fir_pkg, fir_cell.
//
// Usage:
//   The req_ channel carries one beat per item. With req_mode at coefficient
//   write, req_coefficient goes to tap req_tap_index (tap 0 weights the oldest
//   sample); indexes at or above TAPS are dropped. With req_mode at sample,
//   req_sample enters the window. Once TAPS samples have arrived, every sample
//   beat yields one rsp_filtered beat: the 32-bit wrapped dot product of window
//   and coefficients, shifted arithmetically right by 15.
//   Coefficient writes and samples that do not yield a result leave req_ready
//   high. A sample that yields a result appears on rsp_ once the products are
//   formed in parallel and the partial sum has walked the chain one cell per
//   cycle; req_ready stays low meanwhile, so the filter takes no new beat
//   until that result has moved into the result register.
//   The result register frees req_ready while a result waits; if the receiver
//   stalls when the next result is done, it is held in the last cell.
//   Reset clears the coefficients, the fill count and all handshake state.
`timescale 1ns / 1ps

module fir_filter_q15 #(
   parameter int TAPS = 32
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic                                    req_mode,
   input  logic signed [fir_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic        [fir_pkg::TAP_IDX_W-1:0]    req_tap_index,
   input  logic signed [fir_pkg::COEFF_W-1:0]      req_coefficient,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic signed [fir_pkg::OUT_W-1:0]        rsp_filtered
);

   localparam int CNT_W = $clog2(TAPS + 1);

   fir_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   fill_ff, fill_in;
   logic               launch_ff, launch_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [fir_pkg::OUT_W-1:0] rsp_filtered_ff, rsp_filtered_in;

   logic                   accept, take_sample, full_next, out_free;
   fir_pkg::cell_ctrl_type ctrl;

   logic signed [fir_pkg::SAMPLE_W-1:0] sample_link [TAPS+1];
   logic signed [fir_pkg::ACC_W-1:0]    sum_link    [TAPS+1];
   logic                                valid_link  [TAPS+1];
   logic                                coeff_we    [TAPS];

   assign accept      = req_valid && req_ready;
   assign take_sample = accept && (req_mode == fir_pkg::MODE_SAMPLE);
   assign full_next   = (fill_ff == CNT_W'(TAPS)) || (fill_ff == CNT_W'(TAPS - 1));
   assign out_free    = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      ctrl.shift_en   = 1'b0;
      ctrl.prod_en    = 1'b0;
      launch_in       = 1'b0;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_filtered_in = rsp_filtered_ff;
      fill_in         = fill_ff;

      case (state_ff)
         fir_pkg::ST_IDLE: begin
            req_ready     = 1'b1;
            ctrl.shift_en = take_sample;
            if (take_sample) begin
               if (fill_ff != CNT_W'(TAPS)) begin
                  fill_in = fill_ff + CNT_W'(1);
               end
               if (full_next) begin
                  state_in = fir_pkg::ST_PROD;
               end
            end
         end
         fir_pkg::ST_PROD: begin
            ctrl.prod_en = 1'b1;
            launch_in    = 1'b1;
            state_in     = fir_pkg::ST_RUN;
         end
         fir_pkg::ST_RUN, fir_pkg::ST_HOLD: begin
            // The last cell keeps its sum until the result register is free.
            if (valid_link[TAPS] || state_ff == fir_pkg::ST_HOLD) begin
               if (out_free) begin
                  rsp_valid_in    = 1'b1;
                  rsp_filtered_in = sum_link[TAPS][fir_pkg::ACC_W-1:fir_pkg::FRAC_SHIFT];
                  state_in        = fir_pkg::ST_IDLE;
               end else begin
                  state_in = fir_pkg::ST_HOLD;
               end
            end
         end
         default: begin
            state_in = fir_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fir_pkg::ST_IDLE;
         fill_ff      <= '0;
         launch_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         launch_ff    <= launch_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_filtered_ff <= rsp_filtered_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

   // Cell 0 holds the oldest sample; new samples enter at the far end.
   assign sample_link[TAPS] = req_sample;
   assign sum_link[0]       = '0;
   assign valid_link[0]     = launch_ff;

   for (genvar i = 0; i < TAPS; i++) begin : g_cell
      assign coeff_we[i] = accept && (req_mode == fir_pkg::MODE_COEFF)
                           && (int'(req_tap_index) == i);

      fir_cell u_cell (
         .clock          (clock),
         .reset          (reset),
         .ctrl           (ctrl),
         .coeff_we       (coeff_we[i]),
         .coeff_data     (req_coefficient),
         .sample_nbr     (sample_link[i+1]),
         .sample_out     (sample_link[i]),
         .sum_prev       (sum_link[i]),
         .sum_valid_prev (valid_link[i]),
         .sum_out        (sum_link[i+1]),
         .sum_valid_out  (valid_link[i+1])
      );
   end

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for fir_filter_q15: random and directed beats on req_,
// results on rsp_ checked against a behavioral dot-product predictor.
// Depends on fir_pkg and the fir_filter_q15 top level.
`timescale 1ns / 1ps

module testbench;

   localparam int NUM_TAPS     = 32;
   localparam int TARGET_ITEMS = 700;
   localparam int QUIET_TAIL   = 80;
   localparam int STALL_LIMIT  = 2000;
   localparam int SETTLE_WAIT  = 2 * (NUM_TAPS + 2);

   typedef struct {
      logic                                mode;
      logic signed [fir_pkg::SAMPLE_W-1:0] sample;
      logic [fir_pkg::TAP_IDX_W-1:0]       tap;
      logic signed [fir_pkg::COEFF_W-1:0]  coef;
      bit                                  drain;
   } fir_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_mode = fir_pkg::MODE_SAMPLE;
   logic signed [fir_pkg::SAMPLE_W-1:0] req_sample = '0;
   logic [fir_pkg::TAP_IDX_W-1:0] req_tap_index = '0;
   logic signed [fir_pkg::COEFF_W-1:0] req_coefficient = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [fir_pkg::OUT_W-1:0] rsp_filtered;

   fir_beat_type pending_q[$];
   fir_beat_type cur_beat;
   logic signed [fir_pkg::OUT_W-1:0] filtered_q[$];

   // Predictor state: coefficient bank, sample history (index 0 oldest), fill.
   logic signed [fir_pkg::COEFF_W-1:0] coef_bank [NUM_TAPS];
   logic signed [fir_pkg::SAMPLE_W-1:0] hist [NUM_TAPS];
   int unsigned hist_fill;

   int fails = 0;
   int stall_cycles = 0;
   int tx_gap, rx_gap, tx_pct, rx_pct, tx_tick, rx_tick;
   int num_items = 0;
   bit quiet;

   always #4 clock = ~clock;

   fir_filter_q15 DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_sample      (req_sample),
      .req_tap_index   (req_tap_index),
      .req_coefficient (req_coefficient),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_filtered    (rsp_filtered)
   );

   assign quiet = (pending_q.size() < QUIET_TAIL);

   task automatic fir_accept(input fir_beat_type b);
      int acc;
      logic signed [fir_pkg::ACC_W-1:0] scaled;
      if (b.mode == fir_pkg::MODE_COEFF) begin
         coef_bank[b.tap] = b.coef;
      end else begin
         for (int i = 0; i < NUM_TAPS - 1; i++) hist[i] = hist[i + 1];
         hist[NUM_TAPS - 1] = b.sample;
         if (hist_fill < NUM_TAPS) hist_fill++;
         if (hist_fill == NUM_TAPS) begin
            // int arithmetic wraps modulo 2^32 just as the accumulator does.
            acc = 0;
            for (int i = 0; i < NUM_TAPS; i++) acc += int'(hist[i]) * int'(coef_bank[i]);
            scaled = acc >>> fir_pkg::FRAC_SHIFT;
            filtered_q.push_back(scaled[fir_pkg::OUT_W-1:0]);
         end
      end
   endtask

   function automatic logic signed [15:0] pick_value(input int style);
      case (style)
         0: pick_value = 16'($urandom_range(0, 65535));
         1: case ($urandom_range(0, 3))
               0: pick_value = -16'sd32768;
               1: pick_value = 16'sd32767;
               2: pick_value = -16'sd1;
               default: pick_value = 16'sd0;
            endcase
         2: pick_value = 16'($signed($urandom_range(0, 511)) - 256);
         default: pick_value = -16'sd32768;
      endcase
   endfunction

   // Unused fields always carry random junk, which the block must ignore.
   task automatic push_coef(input int tap, input logic signed [15:0] value);
      fir_beat_type b;
      b.mode = fir_pkg::MODE_COEFF;
      b.sample = 16'($urandom);
      b.tap = fir_pkg::TAP_IDX_W'(tap);
      b.coef = value;
      b.drain = 0;
      pending_q.push_back(b);
      num_items++;
   endtask

   task automatic push_sample(input logic signed [15:0] value);
      fir_beat_type b;
      b.mode = fir_pkg::MODE_SAMPLE;
      b.sample = value;
      b.tap = fir_pkg::TAP_IDX_W'($urandom);
      b.coef = 16'($urandom);
      b.drain = 0;
      pending_q.push_back(b);
      num_items++;
   endtask

   task automatic push_drain();
      fir_beat_type b;
      b = '{default: 0};
      b.drain = 1;
      pending_q.push_back(b);
   endtask

   task automatic build_stimulus();
      int style, len;
      // Directed: extreme coefficients at both ends of the bank, then extreme
      // samples while the window is still filling.
      push_coef(0, -16'sd32768);
      push_coef(NUM_TAPS - 1, 16'sd32767);
      push_coef(1, -16'sd1);
      push_coef(16, 16'sd1);
      for (int i = 0; i < 20; i++) push_sample(pick_value(1));
      push_drain();
      // Fill the window so that results are in flight when the sender waits.
      for (int i = 0; i < NUM_TAPS; i++) push_sample(pick_value(2));
      push_drain();
      while (num_items < TARGET_ITEMS) begin
         style = $urandom_range(0, 3);
         case ($urandom_range(0, 5))
            0, 1: begin
               // Reload the whole bank; all-negative full scale can make the sum overflow.
               for (int t = 0; t < NUM_TAPS; t++) push_coef(t, pick_value(style));
            end
            2, 3, 4: begin
               len = $urandom_range(10, 40);
               for (int i = 0; i < len; i++) push_sample(pick_value(style));
            end
            default: begin
               len = $urandom_range(10, 20);
               for (int i = 0; i < len; i++) begin
                  if ($urandom_range(0, 1)) push_coef($urandom_range(0, NUM_TAPS - 1),
                                                      pick_value(0));
                  else push_sample(pick_value(0));
               end
            end
         endcase
         if ($urandom_range(0, 9) == 0) push_drain();
      end
   endtask

   // Driver: presents queued beats, with bursts of idle cycles between them.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         for (int i = 0; i < NUM_TAPS; i++) begin
            coef_bank[i] = '0;
            hist[i] = '0;
         end
         hist_fill = 0;
         tx_gap = 0;
         tx_pct = 0;
         tx_tick = 0;
      end else begin
         if (req_valid && req_ready) fir_accept(cur_beat);
         tx_tick++;
         if (tx_tick % 64 == 0) tx_pct = $urandom_range(0, 3) * 20;
         if (!req_valid || req_ready) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_valid <= 1'b0;
            end else if (pending_q.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending_q[0].drain) begin
               // Hold off until every outstanding result has come back.
               if (filtered_q.size() == 0) void'(pending_q.pop_front());
               req_valid <= 1'b0;
            end else if (!quiet && $urandom_range(0, 99) < tx_pct) begin
               tx_gap = $urandom_range(0, 9);
               req_valid <= 1'b0;
            end else begin
               cur_beat = pending_q.pop_front();
               req_valid <= 1'b1;
               req_mode <= cur_beat.mode;
               req_sample <= cur_beat.sample;
               req_tap_index <= cur_beat.tap;
               req_coefficient <= cur_beat.coef;
            end
         end
      end
   end

   // Monitor: checks each result beat and stalls the result channel at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rx_gap = 0;
         rx_pct = 0;
         rx_tick = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (filtered_q.size() == 0) begin
               $error("filtered: no result expected, got %0d", rsp_filtered);
               fails++;
            end else begin
               if (rsp_filtered !== filtered_q[0]) begin
                  $error("filtered: expected %0d, got %0d", filtered_q[0], rsp_filtered);
                  fails++;
               end
               void'(filtered_q.pop_front());
            end
         end
         rx_tick++;
         if (rx_tick % 64 == 0) rx_pct = $urandom_range(0, 3) * 20;
         if (rx_gap > 0) begin
            rx_gap--;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 99) < rx_pct) begin
            rx_gap = $urandom_range(0, 9);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == STALL_LIMIT) begin
            $display("FAIL");
            $finish;
         end
      end
   end

   initial begin
      build_stimulus();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (pending_q.size() != 0 || req_valid || filtered_q.size() != 0)
         @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
      if (fails == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// ----- fir_filter_q15.f -----
sv/fir_pkg.sv
sv/fir_cell.sv
sv/fir_filter_q15.sv
tb/testbench.sv
